// ===== rtl/ppf_pkg.sv =====
// ppf_pkg: shared types and constants of the parent-pointer forest engine
// command and status codes, datapath command and status structs
// no dependencies
`timescale 1ns / 1ps

package ppf_pkg;

    localparam int VERTEX_W = 6;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LINK        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FIND_ROOT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_BRANCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PATH        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REROOT      = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MUTUAL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CYCLE  = 2'd3;

    // source of the vertex field of an emitted word
    typedef enum logic [1:0] {
        VSEL_ZERO,
        VSEL_CUR,
        VSEL_RDATA
    } vsel_t;

    // controller to datapath
    typedef struct packed {
        logic                load_item;
        logic                restart;
        logic                rd_en;
        logic                rd_from_rdata;
        logic                ld_nxt;
        logic                cur_from_rdata;
        logic                cur_from_nxt;
        logic                ld_prev;
        logic                wr_link;
        logic                wr_rr;
        logic                emit;
        vsel_t               emit_vsel;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } ppf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hp_cur;
        logic hp_p;
        logic mutual;
        logic cnt_full;
        logic out_free;
    } ppf_stat_t;

endpackage

// ===== rtl/parent_pointer_forest_engine_core.sv =====
// parent_pointer_forest_engine_core: top level of the parent-pointer forest engine
// depends on ppf_pkg, ppf_ctrl and ppf_datapath
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | cmd, vertex, new_parent
//  out     | output    | out_valid / out_ready| result_vertex, status, last
//
// One command at a time. Link writes one entry and emits one word; find root and
// find branch walk up the parents one step at a time; path to root and reroot
// first check the whole path and then, from the subject again, emit it or rewrite
// it. The single read port of the parent store sets the pace: one parent fetch per
// step. Reset clears all has-parent flags at once.
// A stalled output word holds the engine only when the next word is due.
`timescale 1ns / 1ps

module parent_pointer_forest_engine_core #(
    parameter int NUM_VERTICES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ppf_pkg::CMD_W-1:0]      cmd,
    input  logic [ppf_pkg::VERTEX_W-1:0]   vertex,
    input  logic [ppf_pkg::VERTEX_W-1:0]   new_parent,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ppf_pkg::VERTEX_W-1:0]   result_vertex,
    output logic [ppf_pkg::STATUS_W-1:0]   status,
    output logic                           last
);
    import ppf_pkg::*;

    ppf_cmd_t  dp_cmd;
    ppf_stat_t dp_stat;

    // sequencer
    ppf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (dp_stat),
        .ctl      (dp_cmd)
    );

    // parent table and walk datapath
    ppf_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .vertex        (vertex),
        .new_parent    (new_parent),
        .ctl           (dp_cmd),
        .stat          (dp_stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_vertex (result_vertex),
        .status        (status),
        .last          (last)
    );

endmodule

// ===== rtl/ppf_datapath.sv =====
// ppf_datapath: parent table, walk registers, step counter and output register
// depends on ppf_pkg; driven by ppf_ctrl through ppf_cmd_t
`timescale 1ns / 1ps

module ppf_datapath #(
    parameter int NUM_VERTICES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ppf_pkg::VERTEX_W-1:0]   vertex,
    input  logic [ppf_pkg::VERTEX_W-1:0]   new_parent,
    input  ppf_pkg::ppf_cmd_t              ctl,
    output ppf_pkg::ppf_stat_t             stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ppf_pkg::VERTEX_W-1:0]   result_vertex,
    output logic [ppf_pkg::STATUS_W-1:0]   status,
    output logic                           last
);
    import ppf_pkg::*;

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int CW = $clog2(NUM_VERTICES + 1);
    localparam logic [VERTEX_W:0] N_LIM = (VERTEX_W + 1)'(NUM_VERTICES);
    localparam logic [CW-1:0]     N_CNT = CW'(NUM_VERTICES);

    // parent index store and has-parent flags
    logic [VERTEX_W-1:0] mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] hp_reg;

    logic [VERTEX_W-1:0] v_reg, np_reg, cur_reg, nxt_reg, prev_reg, rdata_reg;
    logic                first_reg;
    logic [CW-1:0]       cnt_reg;

    logic                out_valid_reg;
    logic [VERTEX_W-1:0] res_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                last_reg;

    logic [VERTEX_W-1:0] raddr;
    logic                wr_en, wr_hp;
    logic [AW-1:0]       wr_addr;
    logic [VERTEX_W-1:0] wr_data;
    logic [VERTEX_W-1:0] emit_v;

    function automatic logic in_range(input logic [VERTEX_W-1:0] x);
        return {1'b0, x} < N_LIM;
    endfunction

    function automatic logic [AW-1:0] idx(input logic [VERTEX_W-1:0] x);
        return x[AW-1:0];
    endfunction

    // status towards the controller
    assign stat.hp_cur   = in_range(cur_reg) && hp_reg[idx(cur_reg)];
    assign stat.hp_p     = in_range(rdata_reg) && hp_reg[idx(rdata_reg)];
    assign stat.mutual   = (rdata_reg == cur_reg);
    assign stat.cnt_full = (cnt_reg >= N_CNT);
    assign stat.out_free = !out_valid_reg || out_ready;

    // read address
    assign raddr = ctl.rd_from_rdata ? rdata_reg : cur_reg;

    // write port: link writes the child, reroot rewrites the current vertex
    always_comb
    begin
        wr_en   = 1'b0;
        wr_hp   = 1'b1;
        wr_addr = idx(v_reg);
        wr_data = np_reg;
        if (ctl.wr_link)
        begin
            wr_en = in_range(v_reg) && in_range(np_reg);
        end
        else if (ctl.wr_rr)
        begin
            wr_en   = in_range(cur_reg);
            wr_hp   = !first_reg;
            wr_addr = idx(cur_reg);
            wr_data = prev_reg;
        end
    end

    // parent index memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[idx(raddr)];
        end
    end

    // has-parent flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg <= '0;
        end
        else if (wr_en)
        begin
            hp_reg[wr_addr] <= wr_hp;
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            v_reg  <= vertex;
            np_reg <= new_parent;
        end
        if (ctl.ld_nxt)
        begin
            nxt_reg <= rdata_reg;
        end
        if (ctl.ld_prev)
        begin
            prev_reg <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (ctl.load_item)
        begin
            cur_reg   <= vertex;
            cnt_reg   <= CW'(1);
            first_reg <= 1'b1;
        end
        else if (ctl.restart)
        begin
            cur_reg   <= v_reg;
            first_reg <= 1'b1;
        end
        else
        begin
            if (ctl.cur_from_rdata)
            begin
                cur_reg <= rdata_reg;
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (ctl.cur_from_nxt)
            begin
                cur_reg <= nxt_reg;
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (ctl.ld_prev)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    // output word source
    always_comb
    begin
        case (ctl.emit_vsel)
            VSEL_CUR:   emit_v = cur_reg;
            VSEL_RDATA: emit_v = rdata_reg;
            default:    emit_v = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_reg  <= emit_v;
            st_reg   <= ctl.emit_status;
            last_reg <= ctl.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_vertex = res_reg;
    assign status        = st_reg;
    assign last          = last_reg;

endmodule

// ===== rtl/ppf_ctrl.sv =====
// ppf_ctrl: command sequencer of the parent-pointer forest engine
// depends on ppf_pkg; steers ppf_datapath through ppf_cmd_t
`timescale 1ns / 1ps

module ppf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ppf_pkg::CMD_W-1:0]   cmd,
    input  ppf_pkg::ppf_stat_t          stat,
    output ppf_pkg::ppf_cmd_t           ctl
);
    import ppf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK,
        S_START,
        S_PSTEP,
        S_PPAIR,
        S_EMIT,
        S_ENEXT,
        S_RREAD,
        S_RWRITE
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] op_reg;
    logic             branch_mode;

    assign branch_mode = op_reg inside {CMD_FIND_ROOT, CMD_FIND_BRANCH};
    assign in_ready    = (state_reg == S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    case (cmd) inside
                        CMD_LINK:
                            state_next = S_LINK;
                        CMD_FIND_ROOT, CMD_FIND_BRANCH, CMD_PATH, CMD_REROOT:
                            state_next = S_START;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            // link: one write and one word
            S_LINK:
            begin
                if (stat.out_free)
                begin
                    ctl.wr_link   = 1'b1;
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            // subject vertex: root answers at once, otherwise fetch its parent
            S_START:
            begin
                if (!stat.hp_cur)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit      = 1'b1;
                        ctl.emit_last = 1'b1;
                        case (op_reg)
                            CMD_FIND_ROOT, CMD_PATH:
                                ctl.emit_vsel = VSEL_CUR;
                            CMD_FIND_BRANCH:
                                ctl.emit_status = ST_ROOT;
                            default:
                                ctl.emit_vsel = VSEL_ZERO;
                        endcase
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_PSTEP;
                end
            end
            // parent of the current vertex is in the read register
            S_PSTEP:
            begin
                if (branch_mode)
                begin
                    if (!stat.hp_p)
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit      = 1'b1;
                            ctl.emit_last = 1'b1;
                            ctl.emit_vsel = (op_reg == CMD_FIND_ROOT) ? VSEL_RDATA
                                                                       : VSEL_CUR;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (stat.cnt_full)
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_last   = 1'b1;
                            ctl.emit_status = ST_CYCLE;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        ctl.rd_en          = 1'b1;
                        ctl.rd_from_rdata  = 1'b1;
                        ctl.cur_from_rdata = 1'b1;
                    end
                end
                else if (stat.hp_p)
                begin
                    // fetch the grandparent for the mutual-parent check
                    ctl.rd_en         = 1'b1;
                    ctl.rd_from_rdata = 1'b1;
                    ctl.ld_nxt        = 1'b1;
                    state_next        = S_PPAIR;
                end
                else if (stat.cnt_full)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_status = ST_CYCLE;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    // path checked: second pass from the subject
                    ctl.restart = 1'b1;
                    state_next  = (op_reg == CMD_PATH) ? S_EMIT : S_RREAD;
                end
            end
            // grandparent is in the read register, parent in nxt
            S_PPAIR:
            begin
                if (stat.mutual || stat.cnt_full)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_status = stat.mutual ? ST_MUTUAL : ST_CYCLE;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.cur_from_nxt = 1'b1;
                    state_next       = S_PSTEP;
                end
            end
            // path to root: one word per vertex
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_vsel = VSEL_CUR;
                    ctl.emit_last = !stat.hp_cur;
                    if (stat.hp_cur)
                    begin
                        ctl.rd_en  = 1'b1;
                        state_next = S_ENEXT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ENEXT:
            begin
                ctl.cur_from_rdata = 1'b1;
                state_next         = S_EMIT;
            end
            // reroot: read the old parent before rewriting the entry
            S_RREAD:
            begin
                if (stat.hp_cur)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_RWRITE;
                end
                else if (stat.out_free)
                begin
                    ctl.wr_rr     = 1'b1;
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RWRITE:
            begin
                ctl.wr_rr          = 1'b1;
                ctl.ld_prev        = 1'b1;
                ctl.cur_from_rdata = 1'b1;
                state_next         = S_RREAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and latched command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_LINK;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load_item)
            begin
                op_reg <= cmd;
            end
        end
    end

endmodule

// ===== bench/tb_parent_pointer_forest_engine_core.sv =====
// tb_parent_pointer_forest_engine_core: self-checking bench for the parent-pointer forest engine
// keeps its own copy of the parent table, predicts every result word and checks it in order
// depends on ppf_pkg and parent_pointer_forest_engine_core
`timescale 1ns / 1ps

module tb_parent_pointer_forest_engine_core;

    import ppf_pkg::*;

    localparam int NUM_VERTICES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_SETTLE     = 300;

    // codes the engine does not decode
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [VERTEX_W-1:0] vtx;
        logic [STATUS_W-1:0] st;
        logic                last;
    } result_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic [VERTEX_W-1:0]  vertex;
    logic [VERTEX_W-1:0]  new_parent;
    logic                 out_valid;
    logic                 out_ready;
    logic [VERTEX_W-1:0]  result_vertex;
    logic [STATUS_W-1:0]  status;
    logic                 last;

    // predicted parent table: bit 6 has-parent, bits 5..0 parent
    logic [6:0]           forest_parent [NUM_VERTICES];
    logic [VERTEX_W-1:0]  path_buf [NUM_VERTICES];
    int                   path_len;
    result_word_t         expected_words [$];
    logic [VERTEX_W-1:0]  recent_vertices [$];

    int                   error_count;
    int                   idle_cycles;
    int                   burst_left;

    logic [CMD_W-1:0]     query_ops [4];
    logic [CMD_W-1:0]     spare_ops [3];

    parent_pointer_forest_engine_core #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .vertex        (vertex),
        .new_parent    (new_parent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_vertex (result_vertex),
        .status        (status),
        .last          (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // forest predictor

    function automatic logic has_parent(input logic [VERTEX_W-1:0] v);
        if (int'(v) >= NUM_VERTICES)
            return 1'b0;
        return forest_parent[v][6];
    endfunction

    function automatic logic [VERTEX_W-1:0] parent_of(input logic [VERTEX_W-1:0] v);
        return forest_parent[v][5:0];
    endfunction

    // climb to the ancestor just below the root
    function automatic logic [STATUS_W-1:0] climb_to_branch(input logic [VERTEX_W-1:0] v,
                                                            output logic [VERTEX_W-1:0] branch);
        logic [VERTEX_W-1:0] cur;
        int                  steps;
        cur    = v;
        steps  = 0;
        branch = '0;
        if (!has_parent(v))
            return ST_ROOT;
        while (has_parent(parent_of(cur)))
        begin
            steps++;
            if (steps >= NUM_VERTICES)
                return ST_CYCLE;
            cur = parent_of(cur);
        end
        branch = cur;
        return ST_OK;
    endfunction

    // collect the path up to the root in path_buf, checking for mutual parents
    function automatic logic [STATUS_W-1:0] trace_root_path(input logic [VERTEX_W-1:0] v);
        logic [VERTEX_W-1:0] cur;
        logic [VERTEX_W-1:0] p;
        int                  n;
        cur         = v;
        n           = 1;
        path_buf[0] = v;
        while (has_parent(cur))
        begin
            p = parent_of(cur);
            if (has_parent(p) && parent_of(p) == cur)
                return ST_MUTUAL;
            if (n >= NUM_VERTICES)
                return ST_CYCLE;
            cur         = p;
            path_buf[n] = cur;
            n++;
        end
        path_len = n;
        return ST_OK;
    endfunction

    task automatic push_word(input logic [VERTEX_W-1:0] v, input logic [STATUS_W-1:0] st,
                             input logic l);
        result_word_t w;
        w.vtx  = v;
        w.st   = st;
        w.last = l;
        expected_words.push_back(w);
    endtask

    // work out the result words of one accepted command and update the table
    task automatic predict_command(input logic [CMD_W-1:0] op, input logic [VERTEX_W-1:0] subj,
                                   input logic [VERTEX_W-1:0] par);
        logic [STATUS_W-1:0] st;
        logic [VERTEX_W-1:0] branch;
        case (op)
            CMD_LINK:
            begin
                if (int'(subj) < NUM_VERTICES && int'(par) < NUM_VERTICES)
                    forest_parent[subj] = {1'b1, par};
                push_word('0, ST_OK, 1'b1);
            end
            CMD_FIND_ROOT:
            begin
                if (!has_parent(subj))
                    push_word(subj, ST_OK, 1'b1);
                else
                begin
                    st = climb_to_branch(subj, branch);
                    if (st != ST_OK)
                        push_word('0, st, 1'b1);
                    else
                        push_word(parent_of(branch), ST_OK, 1'b1);
                end
            end
            CMD_FIND_BRANCH:
            begin
                st = climb_to_branch(subj, branch);
                push_word((st == ST_OK) ? branch : '0, st, 1'b1);
            end
            CMD_PATH:
            begin
                st = trace_root_path(subj);
                if (st != ST_OK)
                    push_word('0, st, 1'b1);
                else
                    for (int i = 0; i < path_len; i++)
                        push_word(path_buf[i], ST_OK, (i + 1 == path_len));
            end
            CMD_REROOT:
            begin
                st = trace_root_path(subj);
                if (st != ST_OK)
                    push_word('0, st, 1'b1);
                else
                begin
                    if (int'(subj) < NUM_VERTICES)
                    begin
                        forest_parent[subj] = '0;
                        for (int i = 1; i < path_len; i++)
                            forest_parent[path_buf[i]] = {1'b1, path_buf[i-1]};
                    end
                    push_word('0, ST_OK, 1'b1);
                end
            end
            default:
            begin
                // undecoded command: no words, table untouched
            end
        endcase
    endtask

    // true when linking child under par would close a loop
    function automatic bit link_closes_loop(input logic [VERTEX_W-1:0] child,
                                            input logic [VERTEX_W-1:0] par);
        logic [VERTEX_W-1:0] cur;
        cur = par;
        for (int steps = 0; steps <= NUM_VERTICES; steps++)
        begin
            if (cur == child)
                return 1'b1;
            if (!has_parent(cur))
                return 1'b0;
            cur = parent_of(cur);
        end
        return 1'b1;
    endfunction

    // sender: bursts of words with random gaps, prediction at acceptance
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [VERTEX_W-1:0] subj,
                             input logic [VERTEX_W-1:0] par);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= op;
        vertex     <= subj;
        new_parent <= par;
        do
            @(posedge clk);
        while (!in_ready);
        predict_command(op, subj, par);
    endtask

    // hold the sender off until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
        burst_left = 0;
    endtask

    task automatic note_recent(input logic [VERTEX_W-1:0] v);
        recent_vertices.push_back(v);
        if (recent_vertices.size() > 10)
            void'(recent_vertices.pop_front());
    endtask

    function automatic logic [VERTEX_W-1:0] pick_vertex();
        if (recent_vertices.size() > 0 && $urandom_range(0, 99) < 60)
            return recent_vertices[$urandom_range(0, recent_vertices.size() - 1)];
        return VERTEX_W'($urandom);
    endfunction

    // fresh forest, undecoded codes, self loops, mutual pairs, a short rerooted tree
    task automatic test_fresh_and_corner_cases();
        send_word(CMD_FIND_ROOT, 6'd0, 6'd63);
        send_word(CMD_FIND_BRANCH, 6'd63, 6'd0);
        send_word(CMD_PATH, 6'd63, VERTEX_W'($urandom));
        send_word(CMD_REROOT, 6'd0, VERTEX_W'($urandom));
        send_word(CMD_SPARE_5, 6'd63, 6'd63);
        send_word(CMD_SPARE_6, 6'd0, 6'd0);
        send_word(CMD_SPARE_7, 6'd21, 6'd42);
        // vertex that is its own parent
        send_word(CMD_LINK, 6'd5, 6'd5);
        send_word(CMD_PATH, 6'd5, VERTEX_W'($urandom));
        send_word(CMD_FIND_ROOT, 6'd5, VERTEX_W'($urandom));
        send_word(CMD_FIND_BRANCH, 6'd5, VERTEX_W'($urandom));
        send_word(CMD_REROOT, 6'd5, VERTEX_W'($urandom));
        // mutual pair reached from below
        send_word(CMD_LINK, 6'd10, 6'd11);
        send_word(CMD_LINK, 6'd11, 6'd10);
        send_word(CMD_LINK, 6'd12, 6'd10);
        send_word(CMD_PATH, 6'd12, VERTEX_W'($urandom));
        // short chain, then turned upside down
        send_word(CMD_LINK, 6'd20, 6'd63);
        send_word(CMD_LINK, 6'd63, 6'd0);
        send_word(CMD_FIND_ROOT, 6'd20, VERTEX_W'($urandom));
        send_word(CMD_FIND_BRANCH, 6'd20, VERTEX_W'($urandom));
        send_word(CMD_PATH, 6'd20, VERTEX_W'($urandom));
        send_word(CMD_REROOT, 6'd20, VERTEX_W'($urandom));
        send_word(CMD_PATH, 6'd0, VERTEX_W'($urandom));
        send_word(CMD_FIND_BRANCH, 6'd63, VERTEX_W'($urandom));
        wait_drained();
    endtask

    // mostly loop-free growth with queries on recent vertices, some raw links and noise
    task automatic test_random_forest();
        int                  sent;
        int                  pick;
        int                  tries;
        bit                  found;
        logic [VERTEX_W-1:0] child;
        logic [VERTEX_W-1:0] par;
        sent = 0;
        while (sent < 30)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3)
                wait_drained();
            if (pick < 30)
            begin
                found = 1'b0;
                tries = 0;
                child = VERTEX_W'($urandom);
                par   = '0;
                while (!found && tries < 8)
                begin
                    par = (recent_vertices.size() > 0 && $urandom_range(0, 1))
                        ? recent_vertices[$urandom_range(0, recent_vertices.size() - 1)]
                        : VERTEX_W'($urandom);
                    found = !link_closes_loop(child, par);
                    tries++;
                end
                if (found)
                begin
                    send_word(CMD_LINK, child, par);
                    note_recent(child);
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                send_word(query_ops[$urandom_range(0, 3)], pick_vertex(), VERTEX_W'($urandom));
                sent++;
            end
            else if (pick < 95)
            begin
                // raw link, may close a loop that later links break again
                child = pick_vertex();
                par   = $urandom_range(0, 1) ? child : VERTEX_W'($urandom);
                send_word(CMD_LINK, child, par);
                sent++;
            end
            else
                send_word(spare_ops[$urandom_range(0, 2)], VERTEX_W'($urandom),
                          VERTEX_W'($urandom));
        end
        wait_drained();
    endtask

    // one chain through every vertex: longest path, reroot, then a three-loop and a self loop
    task automatic test_full_chain();
        logic [VERTEX_W-1:0] chain [NUM_VERTICES];
        logic [VERTEX_W-1:0] tmp;
        logic [VERTEX_W-1:0] top_vertex;
        int                  start;
        int                  k;
        int                  j;
        start      = $urandom_range(0, NUM_VERTICES - 1);
        top_vertex = VERTEX_W'(start);
        for (int i = 0; i < NUM_VERTICES; i++)
            if (!has_parent(VERTEX_W'((start + i) % NUM_VERTICES))
                && top_vertex == VERTEX_W'(start) && has_parent(top_vertex))
                top_vertex = VERTEX_W'((start + i) % NUM_VERTICES);
        k = 0;
        for (int i = 0; i < NUM_VERTICES; i++)
            if (VERTEX_W'(i) != top_vertex)
            begin
                chain[k] = VERTEX_W'(i);
                k++;
            end
        chain[NUM_VERTICES - 1] = top_vertex;
        // shuffle everything below the top
        for (int i = NUM_VERTICES - 2; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = chain[i];
            chain[i] = chain[j];
            chain[j] = tmp;
        end
        for (int i = 0; i < NUM_VERTICES - 1; i++)
            send_word(CMD_LINK, chain[i], chain[i+1]);
        send_word(CMD_PATH, chain[0], VERTEX_W'($urandom));
        send_word(CMD_FIND_ROOT, chain[0], VERTEX_W'($urandom));
        send_word(CMD_FIND_BRANCH, chain[0], VERTEX_W'($urandom));
        send_word(CMD_REROOT, chain[0], VERTEX_W'($urandom));
        send_word(CMD_PATH, chain[NUM_VERTICES - 1], VERTEX_W'($urandom));
        send_word(CMD_FIND_ROOT, chain[NUM_VERTICES - 1], VERTEX_W'($urandom));
        // three-vertex loop at the top of the long chain
        send_word(CMD_LINK, chain[0], chain[2]);
        send_word(CMD_PATH, chain[5], VERTEX_W'($urandom));
        send_word(CMD_FIND_ROOT, chain[5], VERTEX_W'($urandom));
        send_word(CMD_FIND_BRANCH, chain[5], VERTEX_W'($urandom));
        send_word(CMD_REROOT, chain[1], VERTEX_W'($urandom));
        // self loop met part way up
        send_word(CMD_LINK, chain[0], chain[0]);
        send_word(CMD_PATH, chain[1], VERTEX_W'($urandom));
        send_word(CMD_REROOT, chain[3], VERTEX_W'($urandom));
        wait_drained();
    endtask

    // receiver: ready pattern of its own, now and then fully open or mostly shut
    initial
    begin : receiver
        int          ready_left;
        int          mode;
        logic [15:0] ready_bits;
        ready_left = 0;
        ready_bits = '0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_left == 0)
            begin
                mode = $urandom_range(0, 3);
                if (mode == 0)
                    ready_bits = 16'hFFFF;
                else if (mode == 3)
                    ready_bits = 16'($urandom) & 16'($urandom);
                else
                    ready_bits = 16'($urandom) | 16'($urandom);
                ready_left = 16;
            end
            out_ready  <= ready_bits[0];
            ready_bits  = ready_bits >> 1;
            ready_left--;
        end
    end

    // result checker: every accepted word against the oldest prediction
    initial
    begin : result_checker
        result_word_t got;
        result_word_t exp_w;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.vtx  = result_vertex;
                got.st   = status;
                got.last = last;
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word: expected none, got vtx %0d st %0d last %0d",
                             $time, got.vtx, got.st, got.last);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w)
                    begin
                        error_count++;
                        $display("%0t: expected vtx %0d st %0d last %0d, got vtx %0d st %0d last %0d",
                                 $time, exp_w.vtx, exp_w.st, exp_w.last,
                                 got.vtx, got.st, got.last);
                    end
                end
            end
        end
    end

    // cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("parent_pointer_forest_engine_core verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        burst_left   = 0;
        path_len     = 0;
        query_ops    = '{CMD_FIND_ROOT, CMD_FIND_BRANCH, CMD_PATH, CMD_REROOT};
        spare_ops    = '{CMD_SPARE_5, CMD_SPARE_6, CMD_SPARE_7};
        for (int i = 0; i < NUM_VERTICES; i++)
            forest_parent[i] = '0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_LINK;
        vertex     <= '0;
        new_parent <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_and_corner_cases();
        test_random_forest();
        test_full_chain();

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("parent_pointer_forest_engine_core verification clean");
        else
            $display("parent_pointer_forest_engine_core verification failed");
        $finish;
    end

endmodule

// ===== parent_pointer_forest_engine_core.f =====
rtl/ppf_pkg.sv
rtl/ppf_datapath.sv
rtl/ppf_ctrl.sv
rtl/parent_pointer_forest_engine_core.sv
bench/tb_parent_pointer_forest_engine_core.sv
